FILE: hdl/dshot_telemetry_decoder_assert.svh
// Assertion macros used by the telemetry decoder back end.
`ifndef DSHOT_TELEMETRY_DECODER_ASSERT_SVH
`define DSHOT_TELEMETRY_DECODER_ASSERT_SVH

// a implies b in the same cycle
`define DTD_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("decoder check failed");

// a implies b in the next cycle
`define DTD_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("decoder check failed");

`endif

FILE: hdl/dshtd_pkg.sv
// Shared types, constants and lookup functions of the telemetry decoder.
package dshtd_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int RUN_MAX = 16;
	localparam int GCR_BITS = 21;
	localparam logic [25:0] RPM_NUM = 26'd60000000;
	localparam logic [4:0] VOLT_SCALE = 5'd25;

	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_START  = 3'd1;
	localparam logic [2:0] ERR_RUN    = 3'd2;
	localparam logic [2:0] ERR_FEW    = 3'd3;
	localparam logic [2:0] ERR_SYMBOL = 3'd4;
	localparam logic [2:0] ERR_CRC    = 3'd5;

	localparam logic [1:0] REG_POLE_PAIRS = 2'd0;
	localparam logic [1:0] REG_TEMP_CODE  = 2'd1;
	localparam logic [1:0] REG_VOLT_CODE  = 2'd2;
	localparam logic [1:0] REG_CURR_CODE  = 2'd3;

	localparam logic [4:0] SYM_BAD = 5'd16;

	typedef struct packed {
		logic [2:0]  err;
		logic [11:0] payload;
	} entry_t;

	typedef struct packed {
		logic [7:0] pole_pairs;
		logic [3:0] temp_code;
		logic [3:0] volt_code;
		logic [3:0] curr_code;
	} cfg_t;

	// GCR bits produced by a run of n equal samples
	function automatic logic [2:0] run_bits(input logic [4:0] run);
		logic [2:0] r;
		case (run)
			5'd1, 5'd2, 5'd3: r = 3'd1;
			5'd4, 5'd5, 5'd6: r = 3'd2;
			5'd7, 5'd8, 5'd9, 5'd10: r = 3'd3;
			5'd11, 5'd12, 5'd13: r = 3'd4;
			5'd14, 5'd15, 5'd16: r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] sym_to_nib(input logic [4:0] s);
		logic [4:0] n;
		case (s)
			5'h09: n = 5'h9;
			5'h0A: n = 5'hA;
			5'h0B: n = 5'hB;
			5'h0D: n = 5'hD;
			5'h0E: n = 5'hE;
			5'h0F: n = 5'hF;
			5'h12: n = 5'h2;
			5'h13: n = 5'h3;
			5'h15: n = 5'h5;
			5'h16: n = 5'h6;
			5'h17: n = 5'h7;
			5'h19: n = 5'h0;
			5'h1A: n = 5'h8;
			5'h1B: n = 5'h1;
			5'h1D: n = 5'h4;
			5'h1E: n = 5'hC;
			default: n = SYM_BAD;
		endcase
		return n;
	endfunction

endpackage

FILE: hdl/dshtd_fifo.sv
// Small synchronous queue between the decode front and the update back.
module dshtd_fifo #(
	parameter int WIDTH = 15,
	parameter int DEPTH = dshtd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			end
			if (pop && not_empty) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			end
			case ({push && !full, pop && not_empty})
				2'b10: cnt_q <= CW'(cnt_q + 1'b1);
				2'b01: cnt_q <= CW'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

FILE: hdl/dshtd_front.sv
// Front end: start check, serial run-length decode, GCR and CRC check.
module dshtd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [63:0]        raw,
	output logic               q_push,
	output dshtd_pkg::entry_t  q_entry,
	input  logic               q_full
);
	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_SCAN  = 3'd1;
	localparam logic [2:0] F_FLUSH = 3'd2;
	localparam logic [2:0] F_TRIM  = 3'd3;
	localparam logic [2:0] F_CHECK = 3'd4;
	localparam logic [2:0] F_PUSH  = 3'd5;

	logic [2:0]  st_q;
	logic [62:0] sh_q;
	logic [5:0]  cnt_q;
	logic [4:0]  run_q;
	logic        level_q;
	logic [31:0] acc_q;
	logic [6:0]  nbits_q;
	logic [19:0] gcr_q;
	dshtd_pkg::entry_t res_q;

	logic [2:0]  len;
	logic [31:0] acc_push;
	logic [6:0]  shift;
	logic [31:0] trimmed;
	logic [4:0]  nib [4];
	logic        sym_bad;
	logic [15:0] word;
	logic [11:0] payload;
	logic [3:0]  crc;

	// append the pending run to the accumulator
	always_comb begin
		len = dshtd_pkg::run_bits(run_q);
		acc_push = acc_q << len;
		if (level_q) begin
			acc_push = acc_push | ((32'd1 << len) - 32'd1);
		end
	end

	always_comb begin
		shift = 7'(nbits_q - 7'(dshtd_pkg::GCR_BITS));
		trimmed = (shift >= 7'd32) ? 32'd0 : (acc_q >> shift[4:0]);
	end

	always_comb begin
		sym_bad = 1'b0;
		for (int i = 0; i < 4; i++) begin
			nib[i] = dshtd_pkg::sym_to_nib(gcr_q[19 - 5*i -: 5]);
			if (nib[i] == dshtd_pkg::SYM_BAD) begin
				sym_bad = 1'b1;
			end
		end
		word = {nib[0][3:0], nib[1][3:0], nib[2][3:0], nib[3][3:0]};
		payload = word[15:4];
		crc = ~(payload[3:0] ^ payload[7:4] ^ payload[11:8]);
	end

	assign in_ready = (st_q == F_IDLE);
	assign q_push = (st_q == F_PUSH) && !q_full;
	assign q_entry = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (in_valid) begin
						st_q <= raw[63] ? F_PUSH : F_SCAN;
					end
				end
				F_SCAN: begin
					if (sh_q[62] == level_q && run_q == 5'(dshtd_pkg::RUN_MAX)) begin
						st_q <= F_PUSH;
					end else if (cnt_q == 6'd62) begin
						st_q <= F_FLUSH;
					end
				end
				F_FLUSH: st_q <= F_TRIM;
				F_TRIM: st_q <= (nbits_q < 7'(dshtd_pkg::GCR_BITS)) ? F_PUSH : F_CHECK;
				F_CHECK: st_q <= F_PUSH;
				F_PUSH: begin
					if (!q_full) begin
						st_q <= F_IDLE;
					end
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				sh_q <= raw[62:0];
				cnt_q <= '0;
				run_q <= 5'd1;
				level_q <= 1'b0;
				acc_q <= '0;
				nbits_q <= '0;
				res_q <= '{err: dshtd_pkg::ERR_START, payload: '0};
			end
			F_SCAN: begin
				sh_q <= {sh_q[61:0], 1'b0};
				cnt_q <= 6'(cnt_q + 1'b1);
				if (sh_q[62] != level_q) begin
					acc_q <= acc_push;
					nbits_q <= 7'(nbits_q + 7'(len));
					level_q <= ~level_q;
					run_q <= 5'd1;
				end else begin
					run_q <= 5'(run_q + 1'b1);
					if (run_q == 5'(dshtd_pkg::RUN_MAX)) begin
						res_q.err <= dshtd_pkg::ERR_RUN;
					end
				end
			end
			F_FLUSH: begin
				acc_q <= acc_push;
				nbits_q <= 7'(nbits_q + 7'(len));
			end
			F_TRIM: begin
				gcr_q <= trimmed[19:0] ^ trimmed[20:1];
				res_q.err <= dshtd_pkg::ERR_FEW;
			end
			F_CHECK: begin
				res_q.payload <= payload;
				if (sym_bad) begin
					res_q.err <= dshtd_pkg::ERR_SYMBOL;
				end else if (word[3:0] != crc) begin
					res_q.err <= dshtd_pkg::ERR_CRC;
				end else begin
					res_q.err <= dshtd_pkg::ERR_NONE;
				end
			end
			default: ;
		endcase
	end
endmodule

FILE: hdl/dshtd_back.sv
// Back end: stored values, counters, rpm divider and result register.
`include "dshot_telemetry_decoder_assert.svh"
module dshtd_back #(
	parameter int COUNT_WIDTH = dshtd_pkg::COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dshtd_pkg::cfg_t    cfg,
	input  logic               q_valid,
	input  dshtd_pkg::entry_t  q_entry,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [151:0]       out_data
);
	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_MUL  = 2'd1;
	localparam logic [1:0] B_DIV  = 2'd2;
	localparam logic [1:0] B_EMIT = 2'd3;

	logic [1:0]  st_q;
	logic [15:0] period_q, per_q;
	logic [25:0] rpm_q, quo_q;
	logic [7:0]  temp_q, curr_q;
	logic [12:0] volt_q;
	logic [COUNT_WIDTH-1:0] reads_q, errors_q;
	logic [23:0] div_q, rem_q;
	logic [4:0]  dcnt_q;
	logic        ok_q, erpm_q;
	logic [2:0]  code_q;
	logic [3:0]  ety_q;
	logic [7:0]  eval_q;
	logic        out_valid_q;
	logic [151:0] out_data_q;

	logic [24:0] trial;
	logic        fits;
	logic [3:0]  ty;

	assign trial = {rem_q, dshtd_pkg::RPM_NUM[dcnt_q]};
	assign fits = (trial >= {1'b0, div_q});
	assign ty = q_entry.payload[11:8];
	assign q_pop = (st_q == B_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			period_q <= '0;
			rpm_q <= '0;
			temp_q <= '0;
			volt_q <= '0;
			curr_q <= '0;
			reads_q <= '0;
			errors_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in B_EMIT the valid flag is handled below
			if (out_valid_q && out_ready && st_q != B_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				B_IDLE: begin
					if (q_valid) begin
						reads_q <= COUNT_WIDTH'(reads_q + 1'b1);
						if (q_entry.err != dshtd_pkg::ERR_NONE) begin
							errors_q <= COUNT_WIDTH'(errors_q + 1'b1);
							st_q <= B_EMIT;
						end else if (q_entry.payload[8]) begin
							period_q <= 16'({7'd0, q_entry.payload[8:0]} << q_entry.payload[11:9]);
							st_q <= B_MUL;
						end else begin
							if (ty == cfg.temp_code) begin
								temp_q <= q_entry.payload[7:0];
							end else if (ty == cfg.volt_code) begin
								volt_q <= 13'(q_entry.payload[7:0] * dshtd_pkg::VOLT_SCALE);
							end else if (ty == cfg.curr_code) begin
								curr_q <= q_entry.payload[7:0];
							end
							st_q <= B_EMIT;
						end
					end
				end
				B_MUL: st_q <= (cfg.pole_pairs == '0) ? B_EMIT : B_DIV;
				B_DIV: begin
					if (dcnt_q == '0) begin
						rpm_q <= {quo_q[24:0], fits};
						st_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				ok_q <= (q_entry.err == dshtd_pkg::ERR_NONE);
				code_q <= q_entry.err;
				erpm_q <= (q_entry.err == dshtd_pkg::ERR_NONE) && q_entry.payload[8];
				per_q <= 16'({7'd0, q_entry.payload[8:0]} << q_entry.payload[11:9]);
				if (q_entry.err == dshtd_pkg::ERR_NONE && !q_entry.payload[8]) begin
					ety_q <= ty;
					eval_q <= q_entry.payload[7:0];
				end else begin
					ety_q <= '0;
					eval_q <= '0;
				end
			end
			B_MUL: begin
				div_q <= per_q * cfg.pole_pairs;
				rem_q <= '0;
				quo_q <= '0;
				dcnt_q <= 5'd25;
			end
			B_DIV: begin
				rem_q <= fits ? 24'(trial - {1'b0, div_q}) : trial[23:0];
				quo_q <= {quo_q[24:0], fits};
				dcnt_q <= 5'(dcnt_q - 1'b1);
			end
			B_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_data_q <= {32'(errors_q), 32'(reads_q), curr_q, volt_q, temp_q,
						rpm_q, period_q, eval_q, ety_q, erpm_q, code_q, ok_q};
				end
			end
			default: ;
		endcase
	end

	`DTD_ASSERT_IMPL(a_pop_idle, clk, arst_n, q_pop, st_q == B_IDLE)
	`DTD_ASSERT_NEXT(a_err_emit, clk, arst_n, q_pop && q_entry.err != dshtd_pkg::ERR_NONE, st_q == B_EMIT)
	`DTD_ASSERT_IMPL(a_ok_code, clk, arst_n, out_valid_q, out_data_q[0] == (out_data_q[3:1] == dshtd_pkg::ERR_NONE))
	`DTD_ASSERT_IMPL(a_div_cnt, clk, arst_n, st_q == B_DIV, dcnt_q <= 5'd25)
endmodule

FILE: hdl/dshot_telemetry_decoder.sv
// Top level of the bidirectional DShot telemetry decoder.
// Usage:
//  - s_axis: one 64-bit oversampled telemetry word per transaction, MSB
//    received first. m_axis: one 152-bit result per input transaction.
//  - cfg_wr_en/cfg_index/cfg_wdata write pole pairs (0) and the
//    temperature (1), voltage (2) and current (3) type codes; write only
//    while the decoder is idle.
//  - The front scans one sample per cycle, then flushes the last run,
//    trims and checks symbols and CRC. The back stores an extended
//    value directly; for an eRPM frame it multiplies the period by the
//    pole pairs and, unless 0, runs a 26-step restoring divide for the rpm.
//  - The front takes a new word only once the previous one has been
//    pushed into the queue.
//  - A two-entry queue between front and back, and the result register,
//    let the front keep taking words while the receiver stalls; once
//    both fill, s_axis_tready stays low until the result is taken.
//  - Reset clears stored values, counters and config to their defaults
//    (7, 2, 4, 6) and empties the queue.
module dshot_telemetry_decoder #(
	parameter int COUNT_WIDTH = dshtd_pkg::COUNT_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // raw_sample
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// frame_ok, error_code, is_erpm, ext_type, ext_value, period_out, rpm_out,
	// temp_out, volt_out, curr_out, reads_out, errors_out
	output logic [151:0] m_axis_tdata,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_wdata
);
	dshtd_pkg::cfg_t   cfg_q;
	dshtd_pkg::entry_t push_entry, pop_entry;
	logic q_push, q_full, q_pop, q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pole_pairs: 8'd7, temp_code: 4'd2, volt_code: 4'd4, curr_code: 4'd6};
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dshtd_pkg::REG_POLE_PAIRS: cfg_q.pole_pairs <= cfg_wdata;
				dshtd_pkg::REG_TEMP_CODE:  cfg_q.temp_code <= cfg_wdata[3:0];
				dshtd_pkg::REG_VOLT_CODE:  cfg_q.volt_code <= cfg_wdata[3:0];
				dshtd_pkg::REG_CURR_CODE:  cfg_q.curr_code <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	dshtd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.raw      (s_axis_tdata),
		.q_push   (q_push),
		.q_entry  (push_entry),
		.q_full   (q_full)
	);

	dshtd_fifo #(
		.WIDTH ($bits(dshtd_pkg::entry_t)),
		.DEPTH (dshtd_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.rdata     (pop_entry),
		.not_empty (q_valid)
	);

	dshtd_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_entry   (pop_entry),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);
endmodule
